FILE: hdl/shd_pkg.sv
package shd_pkg;

  localparam int BUFFER_SIZE = 64;
  localparam int FILL_LIMIT  = BUFFER_SIZE - 2;
  localparam int FILL_W      = 6;

  localparam logic [7:0] CH_START = 8'h2A;
  localparam logic [7:0] CH_END   = 8'h23;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_NUL   = 8'h00;

  typedef enum logic [1:0] {
    KIND_BYTE         = 2'd0,
    KIND_UNTERMINATED = 2'd1,
    KIND_OVERLONG     = 2'd2
  } kind_t;

  typedef enum logic [4:0] {
    ST_IN      = 5'b00001,
    ST_EXEC    = 5'b00010,
    ST_RD_ADDR = 5'b00100,
    ST_RD_DATA = 5'b01000,
    ST_END     = 5'b10000
  } state_t;

  typedef struct packed {
    logic              we;
    logic [FILL_W-1:0] waddr;
    logic [7:0]        wdata;
    logic              re;
    logic [FILL_W-1:0] raddr;
  } mem_req_t;

endpackage

FILE: hdl/star_hash_reply_deframer.sv
// channel  valid      stall      payload
// rx       rx_valid   rx_stall   rx_byte
// result   res_valid  res_stall  result_kind, frame_byte, last_of_run
//
// A byte is registered in ST_IN and handled in ST_EXEC; rx_stall holds
// off the next byte until it is stored or skipped. On '#' the frame is
// read back from the store word by word (address in ST_RD_ADDR, then
// registered read data in ST_RD_DATA), followed by the '#' itself.
// Reset is synchronous and clears the fill count; store contents are kept.
// res_stall holds the output register and the sequencer behind it.
module star_hash_reply_deframer (
  input  logic       clk,
  input  logic       rst,
  input  logic       rx_valid,
  output logic       rx_stall,
  input  logic [7:0] rx_byte,
  output logic       res_valid,
  input  logic       res_stall,
  output logic [1:0] result_kind,
  output logic [7:0] frame_byte,
  output logic       last_of_run
);

  shd_pkg::mem_req_t req;
  logic [7:0]        rdata;

  shd_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .rx_valid    (rx_valid),
    .rx_stall    (rx_stall),
    .rx_byte     (rx_byte),
    .res_valid   (res_valid),
    .res_stall   (res_stall),
    .result_kind (result_kind),
    .frame_byte  (frame_byte),
    .last_of_run (last_of_run),
    .req         (req),
    .rdata       (rdata)
  );

  shd_store u_store (
    .clk   (clk),
    .req   (req),
    .rdata (rdata)
  );

endmodule

FILE: hdl/shd_store.sv
module shd_store (
  input  logic             clk,
  input  shd_pkg::mem_req_t req,
  output logic [7:0]       rdata
);

  logic [7:0] mem [shd_pkg::BUFFER_SIZE];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    if (req.re) begin
      rdata <= mem[req.raddr];
    end
  end

endmodule

FILE: hdl/shd_ctrl.sv
module shd_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              rx_valid,
  output logic              rx_stall,
  input  logic [7:0]        rx_byte,
  output logic              res_valid,
  input  logic              res_stall,
  output logic [1:0]        result_kind,
  output logic [7:0]        frame_byte,
  output logic              last_of_run,
  output shd_pkg::mem_req_t req,
  input  logic [7:0]        rdata
);

  shd_pkg::state_t            state, state_next;
  logic [shd_pkg::FILL_W-1:0] fill, fill_next;
  logic [shd_pkg::FILL_W-1:0] idx, idx_next;
  logic [7:0]                 rx_hold;
  logic                       out_free;
  logic                       load;
  shd_pkg::kind_t             load_kind;
  logic [7:0]                 load_byte;
  logic                       load_last;

  assign rx_stall = (state != shd_pkg::ST_IN);
  assign out_free = !res_valid || !res_stall;

  always_comb begin
    state_next = state;
    fill_next  = fill;
    idx_next   = idx;
    load       = 1'b0;
    load_kind  = shd_pkg::KIND_BYTE;
    load_byte  = 8'h00;
    load_last  = 1'b0;
    req        = '0;
    case (state)
      shd_pkg::ST_IN: begin
        if (rx_valid) begin
          state_next = shd_pkg::ST_EXEC;
        end
      end
      shd_pkg::ST_EXEC: begin
        if (rx_hold == shd_pkg::CH_START) begin
          if (fill == '0) begin
            req.we     = 1'b1;
            req.wdata  = shd_pkg::CH_START;
            fill_next  = shd_pkg::FILL_W'(1);
            state_next = shd_pkg::ST_IN;
          end else if (out_free) begin
            load       = 1'b1;
            load_kind  = shd_pkg::KIND_UNTERMINATED;
            load_last  = 1'b1;
            req.we     = 1'b1;
            req.wdata  = shd_pkg::CH_START;
            fill_next  = shd_pkg::FILL_W'(1);
            state_next = shd_pkg::ST_IN;
          end
        end else if (fill == '0 ||
                     rx_hold inside {shd_pkg::CH_CR, shd_pkg::CH_LF, shd_pkg::CH_NUL}) begin
          state_next = shd_pkg::ST_IN;
        end else if (rx_hold == shd_pkg::CH_END) begin
          idx_next   = '0;
          state_next = shd_pkg::ST_RD_ADDR;
        end else if (fill >= shd_pkg::FILL_W'(shd_pkg::FILL_LIMIT)) begin
          if (out_free) begin
            load       = 1'b1;
            load_kind  = shd_pkg::KIND_OVERLONG;
            load_last  = 1'b1;
            fill_next  = '0;
            state_next = shd_pkg::ST_IN;
          end
        end else begin
          req.we     = 1'b1;
          req.waddr  = fill;
          req.wdata  = rx_hold;
          fill_next  = fill + shd_pkg::FILL_W'(1);
          state_next = shd_pkg::ST_IN;
        end
      end
      shd_pkg::ST_RD_ADDR: begin
        req.re     = 1'b1;
        req.raddr  = idx;
        state_next = shd_pkg::ST_RD_DATA;
      end
      shd_pkg::ST_RD_DATA: begin
        if (out_free) begin
          load      = 1'b1;
          load_byte = rdata;
          idx_next  = idx + shd_pkg::FILL_W'(1);
          if (idx + shd_pkg::FILL_W'(1) == fill) begin
            state_next = shd_pkg::ST_END;
          end else begin
            state_next = shd_pkg::ST_RD_ADDR;
          end
        end
      end
      shd_pkg::ST_END: begin
        if (out_free) begin
          load       = 1'b1;
          load_byte  = shd_pkg::CH_END;
          load_last  = 1'b1;
          fill_next  = '0;
          state_next = shd_pkg::ST_IN;
        end
      end
      default: begin
        state_next = shd_pkg::ST_IN;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= shd_pkg::ST_IN;
      fill      <= '0;
      idx       <= '0;
      res_valid <= 1'b0;
    end else begin
      state <= state_next;
      fill  <= fill_next;
      idx   <= idx_next;
      if (load) begin
        res_valid <= 1'b1;
      end else if (!res_stall) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == shd_pkg::ST_IN && rx_valid) begin
      rx_hold <= rx_byte;
    end
    if (load) begin
      result_kind <= load_kind;
      frame_byte  <= load_byte;
      last_of_run <= load_last;
    end
  end

endmodule
